// ----- src/binary_slice_boundary_points_assert.svh -----
// ----------------------------------------------------------------------------
// Boundary point extractor assertion macros
// Shared helpers for concurrent checks on the block's internal logic.
// ----------------------------------------------------------------------------
`ifndef BINARY_SLICE_BOUNDARY_POINTS_ASSERT_SVH
`define BINARY_SLICE_BOUNDARY_POINTS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BSBP_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSBP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- src/bsbp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsbp_pkg
// Types and constants shared by the boundary point extractor modules.
// ----------------------------------------------------------------------------
package bsbp_pkg;

   // Field widths of the streams.
   localparam int RED_W   = 8;
   localparam int POINT_W = 10;
   localparam int CSR_W   = 11;
   localparam int STEP_W  = 4;
   localparam int CSR_IDX_W = 2;

   // Number of distinct sample steps the step register can encode (1 .. 15).
   localparam int STEP_MAX = 15;

   // Smallest image size in either direction.
   localparam int MIN_SIZE = 3;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_SAMPLE_STEP  = 2'd2
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [CSR_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [CSR_W-1:0]  HEIGHT_RESET = 11'd1024;
   localparam logic [STEP_W-1:0] STEP_RESET   = 4'd2;

   // Pixel class kept in the line stores.
   typedef enum logic [1:0] {
      CLS_ZERO  = 2'd0,
      CLS_OTHER = 2'd1,
      CLS_FULL  = 2'd2
   } cls_type;

   localparam logic [RED_W-1:0] RED_FULL = 8'd255;

   // Sampling decision for the pixel above the current one.
   typedef struct packed {
      logic col_sample;
      logic row_sample;
   } sample_type;

   function automatic cls_type classify(input logic [RED_W-1:0] red);
      cls_type cls;
      if (red == '0) begin
         cls = CLS_ZERO;
      end else if (red == RED_FULL) begin
         cls = CLS_FULL;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

endpackage

// ----- src/bsbp_ram.sv -----
// ----------------------------------------------------------------------------
// bsbp_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bsbp_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- src/bsbp_pos.sv -----
// ----------------------------------------------------------------------------
// bsbp_pos
// Column, row and slice counters with running residues for every step.
// ----------------------------------------------------------------------------
module bsbp_pos #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_SLICES = 1024,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int RW = $clog2(MAX_HEIGHT),
   localparam int SW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [WW-1:0]              width,
   input  logic [HW-1:0]              height,
   input  logic [bsbp_pkg::STEP_W-1:0] step,
   output logic [CW-1:0]              col,
   output logic [CW-1:0]              col_next,
   output logic [RW-1:0]              row,
   output logic [SW-1:0]              slice,
   output logic                       col_last,
   output bsbp_pkg::sample_type       sample
);

   localparam logic [SW-1:0] SLICE_LAST = SW'(MAX_SLICES - 1);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [SW-1:0] slice_ff, slice_in;
   logic          row_last;
   logic [bsbp_pkg::STEP_W-1:0] sel;
   logic [bsbp_pkg::STEP_W-1:0] col_res_ff [bsbp_pkg::STEP_MAX];
   logic [bsbp_pkg::STEP_W-1:0] row_res_ff [bsbp_pkg::STEP_MAX];

   assign col_last = (16'(col_ff) + 16'd1) >= 16'(width);
   assign row_last = (16'(row_ff) + 16'd1) >= 16'(height);

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      slice_in = slice_ff;
      if (advance) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in = '0;
               if (slice_ff != SLICE_LAST) begin
                  slice_in = slice_ff + SW'(1);
               end
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         slice_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         slice_ff <= slice_in;
      end
   end

   // Residue k tracks (column - 1) mod k and (row - 2) mod k.
   for (genvar i = 0; i < bsbp_pkg::STEP_MAX; i++) begin : g_res
      localparam int K = i + 1;
      localparam logic [bsbp_pkg::STEP_W-1:0] TOP = bsbp_pkg::STEP_W'(K - 1);
      localparam logic [bsbp_pkg::STEP_W-1:0] ROW_START =
         bsbp_pkg::STEP_W'((K - (2 % K)) % K);

      logic [bsbp_pkg::STEP_W-1:0] col_inc, row_inc;

      assign col_inc = (col_res_ff[i] == TOP) ? '0 : col_res_ff[i] + 4'd1;
      assign row_inc = (row_res_ff[i] == TOP) ? '0 : row_res_ff[i] + 4'd1;

      always_ff @(posedge clock) begin
         if (reset) begin
            col_res_ff[i] <= TOP;
            row_res_ff[i] <= ROW_START;
         end else if (advance) begin
            if (col_last) begin
               col_res_ff[i] <= TOP;
               row_res_ff[i] <= row_last ? ROW_START : row_inc;
            end else begin
               col_res_ff[i] <= col_inc;
            end
         end
      end
   end

   // A step of zero behaves as a step of one.
   assign sel = (step == '0) ? '0 : step - 4'd1;

   assign sample.col_sample = (col_ff != '0) && !col_last && (col_res_ff[sel] == '0);
   assign sample.row_sample = (row_ff >= RW'(2)) && (16'(row_ff) < 16'(height)) &&
                              (row_res_ff[sel] == '0);

   assign col      = col_ff;
   assign col_next = col_in;
   assign row      = row_ff;
   assign slice    = slice_ff;

endmodule

// ----- src/binary_slice_boundary_points.sv -----
// ----------------------------------------------------------------------------
// binary_slice_boundary_points
// Extracts 4-neighbour boundary points from a stack of binary image slices.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ stream one per request, in raster order (row 0
// first, column 0 first, slice after slice); only the red byte is used. A
// sampled pixel (off the outer border, column and row equal to 1 plus a
// multiple of sample_step) that is fully set (255) and has a 4-neighbour of
// 0 produces one point on the rsp_ stream carrying its column, the value
// image_height - 1 - row, and the slice number, which saturates at
// MAX_SLICES - 1. The point is issued with the request that brings the pixel
// directly below it, so points come out in raster order of that lower pixel.
// The block takes one pixel every clock cycle: every request is handled in a
// single pass from the registered line-store read to the result register,
// and the line store (MAX_WIDTH entries of two 2-bit classes) does one write
// and two reads each cycle. A pixel is held off only while a point waits in
// the result register and rsp_tready is low. Width and height are clamped to
// 3 .. MAX_WIDTH and 3 .. MAX_HEIGHT, and a step of zero acts as one. The
// configuration registers should be written only between requests; the line
// store needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "binary_slice_boundary_points_assert.svh"

module binary_slice_boundary_points #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_SLICES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   // Pixel requests.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] red
   // Boundary points.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [31:0]                  rsp_tdata,   // [9:0] point_x, [19:10] point_y,
                                                     // [29:20] point_z, [31:30] zero
   // Configuration writes.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bsbp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsbp_pkg::CSR_W-1:0]   csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int SW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   // Configuration registers.
   logic [bsbp_pkg::CSR_W-1:0]  width_ff;
   logic [bsbp_pkg::CSR_W-1:0]  height_ff;
   logic [bsbp_pkg::STEP_W-1:0] step_ff;

   logic [WW-1:0] width_used;
   logic [HW-1:0] height_used;

   // Position tracking.
   logic                 accept;
   logic [CW-1:0]        col, col_next;
   logic [CW:0]          col_right;
   logic [CW-1:0]        rd_addr_b;
   logic [RW-1:0]        row;
   logic [SW-1:0]        slice;
   logic                 col_last;
   bsbp_pkg::sample_type sample;

   // Line store: bits [3:2] hold the row two above, bits [1:0] the row above.
   logic [3:0] cur_entry;
   logic [3:0] right_entry;
   logic [3:0] wr_entry;

   bsbp_pkg::cls_type down_cls, centre_cls, up_cls, right_cls, left_cls;
   logic [1:0]        left_ff;
   logic              emit;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bsbp_pkg::POINT_W-1:0]  point_x_ff, point_y_ff, point_z_ff;
   logic [31:0]                   x_wide, y_wide, z_wide;

   // ------------------------------------------------------------------------
   // Configuration port: always ready, writes beyond the list are dropped.
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bsbp_pkg::WIDTH_RESET;
         height_ff <= bsbp_pkg::HEIGHT_RESET;
         step_ff   <= bsbp_pkg::STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bsbp_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            bsbp_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            bsbp_pkg::CSR_SAMPLE_STEP:  step_ff   <= csr_data[bsbp_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the image size into the supported range.
   always_comb begin
      if (16'(width_ff) < 16'(bsbp_pkg::MIN_SIZE)) begin
         width_used = WW'(bsbp_pkg::MIN_SIZE);
      end else if (16'(width_ff) > 16'(MAX_WIDTH)) begin
         width_used = WW'(MAX_WIDTH);
      end else begin
         width_used = WW'(width_ff);
      end
      if (16'(height_ff) < 16'(bsbp_pkg::MIN_SIZE)) begin
         height_used = HW'(bsbp_pkg::MIN_SIZE);
      end else if (16'(height_ff) > 16'(MAX_HEIGHT)) begin
         height_used = HW'(MAX_HEIGHT);
      end else begin
         height_used = HW'(height_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Handshake: a new pixel is taken whenever the result register is free or
   // is being emptied in the same cycle.
   // ------------------------------------------------------------------------
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   bsbp_pos #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_SLICES (MAX_SLICES)
   ) u_pos (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .width    (width_used),
      .height   (height_used),
      .step     (step_ff),
      .col      (col),
      .col_next (col_next),
      .row      (row),
      .slice    (slice),
      .col_last (col_last),
      .sample   (sample)
   );

   // The store is read ahead through its registered ports at the column of the next pixel and at
   // the column to its right, so both entries are ready when that pixel comes.
   assign col_right = {1'b0, col_next} + (CW + 1)'(1);
   assign rd_addr_b = (col_right == (CW + 1)'(MAX_WIDTH)) ? '0 : col_right[CW-1:0];

   // The row above moves into the row-two-above slot, the new pixel takes
   // its place.
   assign wr_entry = {cur_entry[1:0], down_cls};

   bsbp_ram #(
      .WIDTH (4),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (col),
      .wr_data   (wr_entry),
      .rd_addr_a (col_next),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (cur_entry),
      .rd_data_b (right_entry)
   );

   // ------------------------------------------------------------------------
   // Neighbourhood of the pixel above the incoming one.
   // ------------------------------------------------------------------------
   assign down_cls   = bsbp_pkg::classify(req_tdata);
   assign centre_cls = bsbp_pkg::cls_type'(cur_entry[1:0]);
   assign up_cls     = bsbp_pkg::cls_type'(cur_entry[3:2]);
   assign right_cls  = bsbp_pkg::cls_type'(right_entry[1:0]);
   assign left_cls   = bsbp_pkg::cls_type'(left_ff);

   // The left neighbour is the centre seen with the previous pixel.
   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff <= cur_entry[1:0];
      end
   end

   assign emit = accept && sample.col_sample && sample.row_sample &&
                 (centre_cls == bsbp_pkg::CLS_FULL) &&
                 ((left_cls == bsbp_pkg::CLS_ZERO) || (right_cls == bsbp_pkg::CLS_ZERO) ||
                  (up_cls == bsbp_pkg::CLS_ZERO) || (down_cls == bsbp_pkg::CLS_ZERO));

   // ------------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------------
   assign x_wide = 32'(col);
   assign y_wide = 32'(height_used) - 32'(row);
   assign z_wide = 32'(slice);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         point_x_ff <= x_wide[bsbp_pkg::POINT_W-1:0];
         point_y_ff <= y_wide[bsbp_pkg::POINT_W-1:0];
         point_z_ff <= z_wide[bsbp_pkg::POINT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, point_z_ff, point_y_ff, point_x_ff};

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // A point that is still waiting must hold off further pixels.
   `BSBP_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready, "pixel taken while a point is stalled")
   // The last column of a row sends the next pixel to column zero.
   `BSBP_ASSERT_NEXT(a_row_wrap, clock, reset, accept && col_last, col == '0, "column did not wrap at row end")
   // A point is always emitted off column zero, with the incoming pixel at least two rows down.
   `BSBP_ASSERT_NOW(a_emit_inner, clock, reset, emit, (col != '0) && (row >= RW'(2)), "point emitted on the border")

endmodule

// ----- sim/tb_binary_slice_boundary_points.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary point extractor testbench
// Streams pixel slices through the block under randomized handshakes and
// compares every emitted point with a cycle-free model of the line stores,
// counters and boundary test kept alongside the stimulus.
// ----------------------------------------------------------------------------
module tb_binary_slice_boundary_points;
   import bsbp_pkg::*;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_SLICES = 1024;

   // The result register is loaded from the accepted request; a pixel that
   // produces no point can still be in flight after the last point.
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int PHASE_PIXELS  = 100;
   localparam int WIDE_PIXELS   = 40;

   // Slowest correct run: about 1250 pixels, each with the longest request gap
   // and point stall drawn, plus the register writes. The limit allows many
   // times that.
   localparam int LIMIT_CYCLES = 1000000;

   // The register index that maps to no register; writes to it are ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic [POINT_W-1:0] x;
      logic [POINT_W-1:0] y;
      logic [POINT_W-1:0] z;
   } point_type;

   // One directed pixel. Rows with typed set carry their own expectation,
   // the others are checked against the predictor.
   typedef struct packed {
      logic [RED_W-1:0] red;
      logic             typed;
      logic             has_point;
      point_type        pt;
   } pixel_row_type;

   localparam int DIRECTED_ROWS = 27;

   // Three 3x3 slices. Only the centre is sampled, and it is decided when
   // the pixel below it (the eighth of the slice) arrives.
   pixel_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // Full slice whose only zero is below the centre: one point.
      '{8'd255, 1'b1, 1'b0, '0}, '{8'd255, 1'b1, 1'b0, '0}, '{8'd255, 1'b1, 1'b0, '0},
      '{8'd255, 1'b1, 1'b0, '0}, '{8'd255, 1'b1, 1'b0, '0}, '{8'd255, 1'b1, 1'b0, '0},
      '{8'd255, 1'b1, 1'b0, '0},
      '{8'd0,   1'b1, 1'b1, '{10'd1, 10'd1, 10'd0}},
      '{8'd255, 1'b1, 1'b0, '0},
      // Full centre whose neighbours are set but never zero: no point.
      '{8'd0,   1'b0, 1'b0, '0}, '{8'd1,   1'b0, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0},
      '{8'd128, 1'b0, 1'b0, '0}, '{8'd255, 1'b0, 1'b0, '0}, '{8'd254, 1'b0, 1'b0, '0},
      '{8'd0,   1'b0, 1'b0, '0}, '{8'd255, 1'b0, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0},
      // Full centre with only its right neighbour at zero: one point.
      '{8'd0,   1'b1, 1'b0, '0}, '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b1, 1'b0, '0},
      '{8'd255, 1'b1, 1'b0, '0}, '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b1, 1'b0, '0},
      '{8'd0,   1'b1, 1'b0, '0},
      '{8'd255, 1'b1, 1'b1, '{10'd1, 10'd1, 10'd2}},
      '{8'd0,   1'b1, 1'b0, '0}
   };

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // [7:0] red
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;   // [9:0] point_x, [19:10] point_y,
                                      // [29:20] point_z, [31:30] zero
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_data;

   binary_slice_boundary_points #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_SLICES (MAX_SLICES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------------
   // Predictor state: the register copies, the two line stores of pixel
   // classes and the column, row and slice counters.
   // ------------------------------------------------------------------------
   logic [CSR_W-1:0]  cfg_width  = WIDTH_RESET;
   logic [CSR_W-1:0]  cfg_height = HEIGHT_RESET;
   logic [STEP_W-1:0] cfg_step   = STEP_RESET;
   cls_type           older_row_cls [MAX_WIDTH];
   cls_type           newer_row_cls [MAX_WIDTH];
   int unsigned       pix_col   = 0;
   int unsigned       pix_row   = 0;
   int unsigned       slice_num = 0;

   point_type expected_points [$];
   int        error_count = 0;
   int        cycle_count = 0;
   bit        calm_phase  = 1'b0;
   int        rsp_stall   = 0;

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // Cycles to hold off before the next request, or before taking the next
   // point. Calm phases run both sides flat out.
   function automatic int draw_gap();
      if (calm_phase) return 0;
      return $urandom_range(0, 5);
   endfunction

   // Mostly set and background pixels so that edges are frequent, with some
   // intermediate values that count as neither.
   function automatic logic [RED_W-1:0] draw_red();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return 8'd255;
      if (pick < 85) return 8'd0;
      if (pick < 95) return 8'($urandom_range(1, 254));
      return 8'($urandom_range(0, 255));
   endfunction

   // Advances the predictor by one pixel. Returns 1 with the point when the
   // pixel directly above the incoming one is a boundary point.
   function automatic bit predict_boundary(input logic [RED_W-1:0] red, output point_type pt);
      int unsigned w, h, st, c, r;
      cls_type     cur;
      bit          hit;
      w   = clamp_size(cfg_width, MAX_WIDTH);
      h   = clamp_size(cfg_height, MAX_HEIGHT);
      st  = (cfg_step == '0) ? 1 : cfg_step;
      c   = pix_col;
      r   = pix_row;
      hit = 1'b0;
      pt  = '0;
      if (red == '0) begin
         cur = CLS_ZERO;
      end else if (red == RED_FULL) begin
         cur = CLS_FULL;
      end else begin
         cur = CLS_OTHER;
      end
      // Left of column c the older store already holds the row above.
      if (r >= 2 && r - 1 <= h - 2 && (r - 2) % st == 0 &&
          c >= 1 && c + 1 < w && (c - 1) % st == 0) begin
         if (newer_row_cls[c] == CLS_FULL &&
             (older_row_cls[c-1] == CLS_ZERO || newer_row_cls[c+1] == CLS_ZERO ||
              older_row_cls[c] == CLS_ZERO || cur == CLS_ZERO)) begin
            hit  = 1'b1;
            pt.x = c[POINT_W-1:0];
            pt.y = POINT_W'(h - r);
            pt.z = slice_num[POINT_W-1:0];
         end
      end
      if (c < MAX_WIDTH) begin
         older_row_cls[c] = newer_row_cls[c];
         newer_row_cls[c] = cur;
      end
      // A counter at or past a reduced size ends the row or slice.
      if (c + 1 >= w) begin
         pix_col = 0;
         if (r + 1 >= h) begin
            pix_row = 0;
            if (slice_num < MAX_SLICES - 1) slice_num++;
         end else begin
            pix_row = r + 1;
         end
      end else begin
         pix_col = c + 1;
      end
      return hit;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   // Sends one pixel request and records the point it should release. A row
   // that carries its own expectation overrides the predictor's answer, but
   // the predictor still steps to keep its stores in line.
   task automatic push_pixel(input logic [RED_W-1:0] red, input bit typed,
                             input bit typed_hit, input point_type typed_pt);
      int        gap;
      bit        hit;
      point_type pt;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= red;
      do @(posedge clock); while (!req_tready);
      hit = predict_boundary(red, pt);
      if (typed) begin
         hit = typed_hit;
         pt  = typed_pt;
      end
      if (hit) expected_points = {expected_points, pt};
   endtask

   // Brings the block to rest: every point returned and the pipeline empty.
   task automatic drain_stream();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes width, height and step, and optionally the spare index too.
   task automatic configure(input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h,
                            input logic [STEP_W-1:0] s, input bit poke_spare);
      int                   gap;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_W-1:0]     value;
      for (int k = 0; k < 4; k++) begin
         case (k)
            0: begin
               idx   = CSR_IMAGE_WIDTH;
               value = w;
            end
            1: begin
               idx   = CSR_IMAGE_HEIGHT;
               value = h;
            end
            2: begin
               idx   = CSR_SAMPLE_STEP;
               value = {{(CSR_W-STEP_W){1'b0}}, s};
            end
            default: begin
               idx   = CSR_SPARE_INDEX;
               value = CSR_W'($urandom_range(0, 2047));
            end
         endcase
         if (k < 3 || poke_spare) begin
            gap = draw_gap();
            if (gap > 0) begin
               csr_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            csr_valid <= 1'b1;
            csr_index <= idx;
            csr_data  <= value;
            do @(posedge clock); while (!csr_ready);
            case (idx)
               CSR_IMAGE_WIDTH:  cfg_width  = value;
               CSR_IMAGE_HEIGHT: cfg_height = value;
               CSR_SAMPLE_STEP:  cfg_step   = value[STEP_W-1:0];
               default: ;
            endcase
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic check_point(input logic [31:0] data);
      point_type got, want;
      got.x = data[9:0];
      got.y = data[19:10];
      got.z = data[29:20];
      if (expected_points.size() == 0) begin
         note_error($sformatf("point (%0d,%0d,%0d) with none expected",
                              got.x, got.y, got.z));
      end else begin
         want = expected_points.pop_front();
         if (got.x != want.x || got.y != want.y || got.z != want.z) begin
            note_error($sformatf("point expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                                 want.x, want.y, want.z, got.x, got.y, got.z));
         end
      end
   endtask

   // Point side: check each accepted point, then stall for a drawn number of
   // cycles before taking the next one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_point(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  = 0;
      end else if (rsp_tready) begin
         if (rsp_tvalid) begin
            rsp_stall = draw_gap();
            if (rsp_stall > 0) begin
               rsp_tready <= 1'b0;
               rsp_stall--;
            end
         end
      end else if (rsp_stall == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_stall--;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CSR_W-1:0]  w, h;
      logic [STEP_W-1:0] s;
      int unsigned       n_pix, n_slices;
      int                random_items, phase;

      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_IMAGE_WIDTH;
      csr_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed slices at the smallest size, with a zero step that acts
      // as one.
      configure(11'd3, 11'd3, 4'd0, 1'b0);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         push_pixel(directed_rows[i].red, directed_rows[i].typed,
                    directed_rows[i].has_point, directed_rows[i].pt);
      end

      // A height past the maximum clamps to it, which shows in point_y.
      // The slice is cut short: width and height then drop below the
      // counters, so the next pixel closes the slice.
      drain_stream();
      configure(11'd5, 11'd2047, 4'd1, 1'b0);
      repeat (24) push_pixel(draw_red(), 1'b0, 1'b0, '0);
      drain_stream();
      configure(11'd3, 11'd3, 4'd1, 1'b0);
      repeat (10) push_pixel(draw_red(), 1'b0, 1'b0, '0);

      // Part of a row at full width (the register value clamps to the
      // maximum) with a height below the minimum. A small width then ends
      // that row, and two short rows close the slice.
      drain_stream();
      calm_phase = 1'b1;
      configure(11'd2047, 11'd0, 4'd1, 1'b1);
      repeat (WIDE_PIXELS) push_pixel(draw_red(), 1'b0, 1'b0, '0);
      drain_stream();
      configure(11'd3, 11'd3, 4'd1, 1'b0);
      repeat (1 + 2 * MIN_SIZE) push_pixel(draw_red(), 1'b0, 1'b0, '0);

      // Random phases of whole slices: first large steps, sizes below the minimum
      // and a zero step, then random settings with mostly small images.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               w = 11'd12;
               h = 11'd10;
               s = 4'd8;
            end
            1: begin
               w = 11'd20;
               h = 11'd9;
               s = 4'd15;
            end
            2: begin
               w = 11'd1;
               h = 11'd2;
               s = 4'd3;
            end
            3: begin
               w = 11'd8;
               h = 11'd7;
               s = 4'd0;
            end
            default: begin
               w = ($urandom_range(0, 9) == 0) ? CSR_W'($urandom_range(0, 2))
                                               : CSR_W'($urandom_range(3, 14));
               h = ($urandom_range(0, 9) == 0) ? CSR_W'($urandom_range(0, 2))
                                               : CSR_W'($urandom_range(3, 10));
               s = ($urandom_range(0, 2) == 0) ? STEP_W'($urandom_range(0, 15))
                                               : STEP_W'($urandom_range(1, 3));
            end
         endcase
         drain_stream();
         calm_phase = ($urandom_range(0, 3) == 0);
         configure(w, h, s, $urandom_range(0, 3) == 0);
         n_pix    = clamp_size(w, MAX_WIDTH) * clamp_size(h, MAX_HEIGHT);
         n_slices = (n_pix >= PHASE_PIXELS) ? 1 : PHASE_PIXELS / n_pix;
         repeat (n_slices * n_pix) push_pixel(draw_red(), 1'b0, 1'b0, '0);
         random_items += n_slices * n_pix;
         phase++;
      end

      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/bsbp_pkg.sv
src/bsbp_ram.sv
src/bsbp_pos.sv
src/binary_slice_boundary_points.sv
sim/tb_binary_slice_boundary_points.sv
